[hdl/salru_pkg.sv]
`timescale 1ns / 1ps

package salru_pkg;

    localparam int TAG_W  = 64;
    localparam int AGE_W  = 3;
    localparam int RAW_W  = 15;
    localparam int CFG_W  = 6;

    localparam logic [AGE_W-1:0] AGE_TOP  = 3'd7;
    localparam logic [AGE_W:0]   AGE_FILL = 4'd8;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;
    localparam logic [1:0] MODE_FETCH  = 2'd3;

    localparam logic [1:0] CFG_SET_BITS  = 2'd0;
    localparam logic [1:0] CFG_WAYS      = 2'd1;
    localparam logic [1:0] CFG_BLK_BITS  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_Q,
        ST_MUL_QM,
        ST_SET,
        ST_READ,
        ST_UPDATE
    } state_t;

endpackage

[hdl/set_assoc_cache_lru_sim.sv]
`timescale 1ns / 1ps
// A load or store steps through ST_MUL_Q, ST_MUL_QM, ST_SET and ST_UPDATE; its result
//   is registered out of ST_UPDATE, which waits while a result is stalled. A modify
//   reads the set again in ST_READ for its second result. A fetch gets no result.
//   The index reduction multipliers and the set memory read-modify-write keep s_ready
//   low until an access has emitted its last result. Reset: synchronous, active low;
//   then a clearing pass writes every set row to invalid before any transaction is taken.
module set_assoc_cache_lru_sim #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_index,
    input  logic [salru_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [63:0]                     s_address,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic                            m_miss,
    output logic                            m_eviction,
    output logic                            m_last,
    output logic [31:0]                     m_hit_total,
    output logic [31:0]                     m_miss_total,
    output logic [31:0]                     m_eviction_total
);
    import salru_pkg::*;

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int MOD_SH  = 32;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << MOD_SH) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS);
    localparam logic [32:0] RECIP   = RECIP64[32:0];
    localparam logic [RAW_W-1:0] SETS_C = RAW_W'(MAX_SETS);

    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
        logic [MAX_WAYS-1:0][AGE_W-1:0] age;
        logic [MAX_WAYS-1:0]            valid;
    } row_t;

    row_t mem [MAX_SETS];

    state_t state_reg, state_next;

    logic [3:0]       set_bits_reg;
    logic [3:0]       ways_reg;
    logic [CFG_W-1:0] blk_bits_reg;

    logic [SET_W-1:0] clr_reg, clr_next;
    logic [1:0]       mode_reg, mode_next;
    logic             second_reg, second_next;
    logic [RAW_W-1:0] raw_reg, raw_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [RAW_W-1:0] q_reg, q_next;
    logic [RAW_W-1:0] qm_reg, qm_next;
    logic [SET_W-1:0] set_reg, set_next;
    row_t             rd_row_reg;

    logic        m_valid_reg, m_valid_next;
    logic        m_hit_reg, m_hit_next;
    logic        m_miss_reg, m_miss_next;
    logic        m_ev_reg, m_ev_next;
    logic        m_last_reg, m_last_next;
    logic [31:0] hits_reg, hits_next;
    logic [31:0] misses_reg, misses_next;
    logic [31:0] evs_reg, evs_next;

    logic             rd_en;
    logic [SET_W-1:0] rd_addr;
    logic             mem_we;
    logic [SET_W-1:0] wr_addr;
    row_t             wr_row;

    logic [63:0]       shifted;
    logic [RAW_W-1:0]  idx_mask;
    logic [6:0]        tag_sh;
    logic [47:0]       prod;
    logic [RAW_W-1:0]  rem;
    logic [5:0]        ways_eff;
    logic [MAX_WAYS-1:0] in_use;
    logic              hit_found, free_found, can_emit;
    logic [WAY_W-1:0]  hit_way, free_way, best_way, way_sel;
    logic [AGE_W:0]    old_age;
    logic              is_hit, is_ev;
    row_t              new_row;

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_miss           = m_miss_reg;
    assign m_eviction       = m_ev_reg;
    assign m_last           = m_last_reg;
    assign m_hit_total      = hits_reg;
    assign m_miss_total     = misses_reg;
    assign m_eviction_total = evs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg <= 4'd4;
            ways_reg     <= 4'd1;
            blk_bits_reg <= CFG_W'(4);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SET_BITS: set_bits_reg <= cfg_wdata[3:0];
                CFG_WAYS:     ways_reg     <= cfg_wdata[3:0];
                CFG_BLK_BITS: blk_bits_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_reg <= mem[rd_addr];
        end
        if (mem_we) begin
            mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            evs_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            hits_reg    <= hits_next;
            misses_reg  <= misses_next;
            evs_reg     <= evs_next;
        end
        mode_reg   <= mode_next;
        second_reg <= second_next;
        raw_reg    <= raw_next;
        tag_reg    <= tag_next;
        q_reg      <= q_next;
        qm_reg     <= qm_next;
        set_reg    <= set_next;
        m_hit_reg  <= m_hit_next;
        m_miss_reg <= m_miss_next;
        m_ev_reg   <= m_ev_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        shifted  = s_address >> blk_bits_reg;
        idx_mask = ~(15'h7FFF << set_bits_reg);
        tag_sh   = {1'b0, blk_bits_reg} + {3'b000, set_bits_reg};
        prod     = raw_reg * RECIP;
        rem      = raw_reg - qm_reg;
        if (rem >= SETS_C) begin
            rem = rem - SETS_C;
        end

        ways_eff = {2'b00, ways_reg};
        if (ways_reg == 4'd0) begin
            ways_eff = 6'd1;
        end
        if (ways_eff > 6'(MAX_WAYS)) begin
            ways_eff = 6'(MAX_WAYS);
        end

        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        for (int j = MAX_WAYS - 1; j >= 0; j--) begin
            in_use[j] = (6'(j) < ways_eff);
            if (in_use[j] && rd_row_reg.valid[j] && rd_row_reg.tag[j] == tag_reg) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(j);
            end
            if (in_use[j] && !rd_row_reg.valid[j]) begin
                free_found = 1'b1;
                free_way   = WAY_W'(j);
            end
        end
        best_way = '0;
        for (int j = 1; j < MAX_WAYS; j++) begin
            if (in_use[j] && rd_row_reg.age[j] > rd_row_reg.age[best_way]) begin
                best_way = WAY_W'(j);
            end
        end

        is_hit = hit_found;
        is_ev  = 1'b0;
        if (hit_found) begin
            way_sel = hit_way;
            old_age = {1'b0, rd_row_reg.age[hit_way]};
        end else if (free_found) begin
            way_sel = free_way;
            old_age = AGE_FILL;
        end else begin
            way_sel = best_way;
            old_age = {1'b0, rd_row_reg.age[best_way]};
            is_ev   = 1'b1;
        end

        new_row = rd_row_reg;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (in_use[j] && WAY_W'(j) != way_sel && rd_row_reg.valid[j]
                    && {1'b0, rd_row_reg.age[j]} < old_age
                    && rd_row_reg.age[j] < AGE_TOP) begin
                new_row.age[j] = rd_row_reg.age[j] + 3'd1;
            end
        end
        new_row.age[way_sel] = '0;
        if (!is_hit) begin
            new_row.valid[way_sel] = 1'b1;
            new_row.tag[way_sel]   = tag_reg;
        end

        can_emit = !m_valid_reg || m_ready;

        state_next   = state_reg;
        clr_next     = clr_reg;
        mode_next    = mode_reg;
        second_next  = second_reg;
        raw_next     = raw_reg;
        tag_next     = tag_reg;
        q_next       = q_reg;
        qm_next      = qm_reg;
        set_next     = set_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_hit_next   = m_hit_reg;
        m_miss_next  = m_miss_reg;
        m_ev_next    = m_ev_reg;
        m_last_next  = m_last_reg;
        hits_next    = hits_reg;
        misses_next  = misses_reg;
        evs_next     = evs_reg;
        rd_en        = 1'b0;
        rd_addr      = set_reg;
        mem_we       = 1'b0;
        wr_addr      = set_reg;
        wr_row       = new_row;

        case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                wr_addr  = clr_reg;
                wr_row   = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SET_W'(MAX_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next   = s_mode;
                    second_next = 1'b0;
                    raw_next    = shifted[RAW_W-1:0] & idx_mask;
                    tag_next    = (tag_sh >= 7'd64) ? '0 : (s_address >> tag_sh[5:0]);
                    if (s_mode != MODE_FETCH) begin
                        state_next = ST_MUL_Q;
                    end
                end
            end
            ST_MUL_Q: begin
                q_next     = prod[MOD_SH+RAW_W-1:MOD_SH];
                state_next = ST_MUL_QM;
            end
            ST_MUL_QM: begin
                qm_next    = q_reg * SETS_C;
                state_next = ST_SET;
            end
            ST_SET: begin
                set_next   = rem[SET_W-1:0];
                rd_en      = 1'b1;
                rd_addr    = rem[SET_W-1:0];
                state_next = ST_UPDATE;
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (can_emit) begin
                    mem_we       = 1'b1;
                    m_valid_next = 1'b1;
                    m_hit_next   = is_hit;
                    m_miss_next  = !is_hit;
                    m_ev_next    = is_ev;
                    m_last_next  = !(mode_reg == MODE_MODIFY && !second_reg);
                    hits_next    = hits_reg + 32'(is_hit);
                    misses_next  = misses_reg + 32'(!is_hit);
                    evs_next     = evs_reg + 32'(is_ev);
                    if (mode_reg == MODE_MODIFY && !second_reg) begin
                        second_next = 1'b1;
                        state_next  = ST_READ;
                    end else begin
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/salru_chk.sv]
`timescale 1ns / 1ps

module salru_chk (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [1:0]                  s_mode,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_hit,
    input logic                        m_miss,
    input logic                        m_eviction,
    input logic                        m_last,
    input logic [31:0]                 m_hit_total,
    input logic [31:0]                 m_miss_total
);
    import salru_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block not quiet after reset");

    a_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit != m_miss) && (!m_eviction || m_miss))
        else $error("inconsistent hit, miss and eviction flags");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode != MODE_FETCH |=> !s_ready)
        else $error("access transaction did not hold off the input");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_total)
            && $stable(m_miss_total) && $stable(m_last))
        else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru_sim salru_chk u_salru_chk (.*);

[verif/set_assoc_cache_lru_sim_tb.sv]
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim_tb;
    import salru_pkg::*;

    localparam int NUM_SETS = 256;
    localparam int NUM_WAYS = 8;
    localparam int HANG_LIMIT = 4000;

    typedef struct packed {
        logic        hit;
        logic        miss;
        logic        eviction;
        logic        last;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } lookup_result_t;

    class cache_scoreboard;
        bit          line_valid [NUM_SETS*NUM_WAYS];
        logic [63:0] line_tag   [NUM_SETS*NUM_WAYS];
        bit [2:0]    line_age   [NUM_SETS*NUM_WAYS];
        int unsigned set_bits;
        int unsigned ways_cfg;
        int unsigned blk_bits;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
        lookup_result_t expected_q[$];
        int          mismatches;

        function new();
            set_bits   = 4;
            ways_cfg   = 1;
            blk_bits   = 4;
            hits       = '0;
            misses     = '0;
            evictions  = '0;
            mismatches = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_SET_BITS: set_bits = value[3:0];
                CFG_WAYS:     ways_cfg = value[3:0];
                CFG_BLK_BITS: blk_bits = value;
                default: ;
            endcase
        endfunction

        function int unsigned ways_active();
            if (ways_cfg == 0) return 1;
            if (ways_cfg > NUM_WAYS) return NUM_WAYS;
            return ways_cfg;
        endfunction

        // make way w most recent; valid ways younger than old_age grow one step older
        function void promote(int unsigned base, int unsigned ways, int unsigned w,
                              int unsigned old_age);
            for (int unsigned j = 0; j < ways; j++) begin
                if (j != w && line_valid[base+j] && line_age[base+j] < old_age &&
                    line_age[base+j] < AGE_TOP) begin
                    line_age[base+j] = line_age[base+j] + 3'd1;
                end
            end
            line_age[base+w] = '0;
        endfunction

        function void lookup(logic [63:0] address, bit last);
            logic [63:0]    mask;
            logic [63:0]    tag;
            int unsigned    set_idx;
            int unsigned    base;
            int unsigned    ways;
            int unsigned    victim;
            bit             hit;
            bit             ev;
            lookup_result_t res;
            mask    = (64'd1 << set_bits) - 64'd1;
            set_idx = int'(((address >> blk_bits) & mask) % NUM_SETS);
            tag     = (blk_bits + set_bits >= 64) ? 64'd0 : address >> (blk_bits + set_bits);
            base    = set_idx * NUM_WAYS;
            ways    = ways_active();
            hit     = 1'b0;
            ev      = 1'b0;
            for (int unsigned j = 0; j < ways; j++) begin
                if (line_valid[base+j] && line_tag[base+j] == tag) begin
                    hit = 1'b1;
                    promote(base, ways, j, line_age[base+j]);
                    break;
                end
            end
            if (!hit) begin
                victim = ways;
                for (int unsigned j = 0; j < ways; j++) begin
                    if (!line_valid[base+j]) begin
                        victim = j;
                        break;
                    end
                end
                if (victim < ways) begin
                    line_valid[base+victim] = 1'b1;
                    line_tag[base+victim]   = tag;
                    promote(base, ways, victim, AGE_FILL);
                end else begin
                    ev     = 1'b1;
                    victim = 0;
                    for (int unsigned j = 1; j < ways; j++) begin
                        if (line_age[base+j] > line_age[base+victim]) victim = j;
                    end
                    line_tag[base+victim] = tag;
                    promote(base, ways, victim, line_age[base+victim]);
                end
            end
            hits      += 32'(hit);
            misses    += 32'(!hit);
            evictions += 32'(ev);
            res = '{hit, !hit, ev, last, hits, misses, evictions};
            expected_q.push_back(res);
        endfunction

        function void note_access(logic [1:0] mode, logic [63:0] address);
            case (mode)
                MODE_FETCH: ;
                MODE_MODIFY: begin
                    lookup(address, 1'b0);
                    lookup(address, 1'b1);
                end
                default: lookup(address, 1'b1);
            endcase
        endfunction

        function void flag(string msg);
            if (mismatches < 10) $display("%0t: %s", $time, msg);
            mismatches++;
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t exp;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result hit=%0b miss=%0b ev=%0b last=%0b",
                               got.hit, got.miss, got.eviction, got.last));
                return;
            end
            exp = expected_q.pop_front();
            if (got.hit !== exp.hit || got.miss !== exp.miss ||
                got.eviction !== exp.eviction || got.last !== exp.last ||
                got.hit_total !== exp.hit_total || got.miss_total !== exp.miss_total ||
                got.eviction_total !== exp.eviction_total) begin
                flag($sformatf({"mismatch expected h/m/e/l=%0b%0b%0b%0b totals=%0d/%0d/%0d,",
                                " got h/m/e/l=%0b%0b%0b%0b totals=%0d/%0d/%0d"},
                               exp.hit, exp.miss, exp.eviction, exp.last, exp.hit_total,
                               exp.miss_total, exp.eviction_total, got.hit, got.miss,
                               got.eviction, got.last, got.hit_total, got.miss_total,
                               got.eviction_total));
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_mode;
    logic [63:0]       s_address;
    logic              m_valid;
    logic              m_ready;
    logic              m_hit;
    logic              m_miss;
    logic              m_eviction;
    logic              m_last;
    logic [31:0]       m_hit_total;
    logic [31:0]       m_miss_total;
    logic [31:0]       m_eviction_total;

    cache_scoreboard   sb;
    bit                send_idle_on   = 1'b1;
    bit                recv_idle_on   = 1'b1;
    bit                recv_long_hold = 1'b0;
    int                quiet_cycles   = 0;

    int unsigned cfg_plan [8][3] = '{
        '{3, 4, 4}, '{0, 8, 0}, '{8, 2, 6}, '{15, 15, 63},
        '{2, 0, 32}, '{5, 8, 58}, '{1, 3, 60}, '{6, 6, 5}
    };

    set_assoc_cache_lru_sim #(
        .MAX_SETS(NUM_SETS),
        .MAX_WAYS(NUM_WAYS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_address       (s_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_miss          (m_miss),
        .m_eviction      (m_eviction),
        .m_last          (m_last),
        .m_hit_total     (m_hit_total),
        .m_miss_total    (m_miss_total),
        .m_eviction_total(m_eviction_total)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic write_cfg(input logic [1:0] idx, input int unsigned value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = CFG_W'(value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_register(idx, CFG_W'(value));
    endtask

    task automatic configure(input int unsigned sets, input int unsigned ways,
                             input int unsigned blk);
        write_cfg(CFG_SET_BITS, sets);
        write_cfg(CFG_WAYS, ways);
        write_cfg(CFG_BLK_BITS, blk);
    endtask

    task automatic send_access(input logic [1:0] mode, input logic [63:0] address);
        if (send_idle_on && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_mode    = mode;
        s_address = address;
        do @(posedge aclk); while (!s_ready);
        sb.note_access(mode, address);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic run_random_phase(input int unsigned sets, input int unsigned ways,
                                    input int unsigned blk, input int accesses,
                                    input bit long_hold);
        int          done;
        logic [1:0]  mode;
        logic [63:0] address;
        int unsigned b;
        int unsigned s;
        drain();
        configure(sets, ways, blk);
        if (long_hold) recv_long_hold = 1'b1;
        b    = sb.blk_bits;
        s    = sb.set_bits;
        done = 0;
        while (done < accesses) begin
            mode = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0) begin
                address = {$urandom, $urandom};
            end else begin
                address = {$urandom, $urandom} & ((64'd1 << b) - 64'd1);
                address |= (64'($urandom_range(0, 3)) & ((64'd1 << s) - 64'd1)) << b;
                if (b + s < 64) begin
                    address |= 64'($urandom_range(0, sb.ways_active() + 2)) << (b + s);
                end
            end
            send_access(mode, address);
            if (mode != MODE_FETCH) done++;
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (recv_long_hold) begin
                recv_long_hold = 1'b0;
                stall_left     = 300;
            end else if (stall_left == 0 && recv_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result('{m_hit, m_miss, m_eviction, m_last,
                              m_hit_total, m_miss_total, m_eviction_total});
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("set_assoc_cache_lru_sim_tb NOT OK");
            $finish;
        end
    end

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_SET_BITS;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_mode    = MODE_LOAD;
        s_address = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        configure(4, 2, 4);
        send_access(MODE_LOAD, 64'h0);
        send_access(MODE_LOAD, 64'h8);
        send_access(MODE_STORE, 64'h10);
        send_access(MODE_MODIFY, 64'h100);
        send_access(MODE_LOAD, 64'h200);
        send_access(MODE_FETCH, 64'h0);
        send_access(MODE_LOAD, '1);
        send_access(MODE_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_access(MODE_LOAD, 64'h5555_5555_5555_5555);
        send_access(MODE_MODIFY, '1);

        // over-wide index, zero ways, tag shifted out entirely
        drain();
        configure(15, 0, 63);
        send_access(MODE_LOAD, 64'h0);
        send_access(MODE_LOAD, 64'h8000_0000_0000_0000);
        send_access(MODE_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
        send_access(MODE_LOAD, '1);

        // one set, way count clamped; walk past capacity to drive ages up to AGE_TOP
        drain();
        configure(0, 15, 0);
        for (int i = 0; i < 10; i++) send_access(MODE_LOAD, 64'(i));

        for (int p = 0; p < 8; p++) begin
            if (p == 7) begin
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
            end
            run_random_phase(cfg_plan[p][0], cfg_plan[p][1], cfg_plan[p][2], 54, p == 0);
        end

        drain();
        if (sb.expected_q.size() != 0) sb.flag("results still outstanding at end of run");
        if (sb.mismatches == 0) begin
            $display("set_assoc_cache_lru_sim_tb OK");
        end else begin
            $display("set_assoc_cache_lru_sim_tb NOT OK");
        end
        $finish;
    end

endmodule
